// ----- rtl/core/gcra_pkg.sv -----
`timescale 1ns / 1ps
// gcra_pkg: move codes, register numbers and helper functions for the
// geometry coprocessor register file. No dependencies.
package gcra_pkg;

  typedef enum logic [1:0] {
    ACT_DATA_RD = 2'd0,
    ACT_DATA_WR = 2'd1,
    ACT_CTRL_RD = 2'd2,
    ACT_CTRL_WR = 2'd3
  } action_t;

  // data bank register numbers
  localparam logic [4:0] D_VZ0  = 5'd1;
  localparam logic [4:0] D_VZ1  = 5'd3;
  localparam logic [4:0] D_VZ2  = 5'd5;
  localparam logic [4:0] D_OTZ  = 5'd7;
  localparam logic [4:0] D_IR0  = 5'd8;
  localparam logic [4:0] D_IR1  = 5'd9;
  localparam logic [4:0] D_IR2  = 5'd10;
  localparam logic [4:0] D_IR3  = 5'd11;
  localparam logic [4:0] D_SXY0 = 5'd12;
  localparam logic [4:0] D_SXY1 = 5'd13;
  localparam logic [4:0] D_SXY2 = 5'd14;
  localparam logic [4:0] D_SXYP = 5'd15;
  localparam logic [4:0] D_SZ0  = 5'd16;
  localparam logic [4:0] D_SZ1  = 5'd17;
  localparam logic [4:0] D_SZ2  = 5'd18;
  localparam logic [4:0] D_SZ3  = 5'd19;
  localparam logic [4:0] D_IRGB = 5'd28;
  localparam logic [4:0] D_ORGB = 5'd29;
  localparam logic [4:0] D_LZCS = 5'd30;
  localparam logic [4:0] D_LZCR = 5'd31;

  // control bank register numbers; all but C_FLAG hold 16-bit signed values
  localparam logic [4:0] C_RT33 = 5'd4;
  localparam logic [4:0] C_LL33 = 5'd12;
  localparam logic [4:0] C_LC33 = 5'd20;
  localparam logic [4:0] C_PRJH = 5'd26;
  localparam logic [4:0] C_DQA  = 5'd27;
  localparam logic [4:0] C_ZSF3 = 5'd29;
  localparam logic [4:0] C_ZSF4 = 5'd30;
  localparam logic [4:0] C_FLAG = 5'd31;

  localparam logic [31:0] FLAG_MASK = 32'h7fff_f000;
  localparam logic [31:0] FLAG_ERR  = 32'h7f87_e000;

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  // one 5-bit colour field: (signed 16-bit >> 7) clamped to 0..31
  function automatic logic [4:0] colour_part(input logic [31:0] r);
    logic [4:0] res;
    if (r[15]) begin
      res = 5'd0;
    end else if (|r[14:12]) begin
      res = 5'd31;
    end else begin
      res = r[11:7];
    end
    return res;
  endfunction

  // count of leading bits equal to bit 31, as a 5-level leading-zero tree
  function automatic logic [5:0] sign_run(input logic [31:0] v);
    logic [31:0] x;
    logic [5:0]  n;
    x = v ^ {32{v[31]}};
    n = 6'd0;
    if (x[31:16] == 16'd0) begin
      n = n + 6'd16;
      x = x << 16;
    end
    if (x[31:24] == 8'd0) begin
      n = n + 6'd8;
      x = x << 8;
    end
    if (x[31:28] == 4'd0) begin
      n = n + 6'd4;
      x = x << 4;
    end
    if (x[31:30] == 2'd0) begin
      n = n + 6'd2;
      x = x << 2;
    end
    if (x[31] == 1'b0) begin
      n = n + 6'd1;
      x = x << 1;
    end
    if (x[31] == 1'b0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/geometry_coprocessor_register_access.sv -----
`timescale 1ns / 1ps
// geometry_coprocessor_register_access: data and control register banks of the
// geometry coprocessor with their move logic. Depends on gcra_pkg.

// A move is taken whenever start is high and busy is low, one move per clock.
// busy is high only while rst_n is held low. Each move produces one result,
// shown on out_read_data with out_valid high for exactly one cycle, after the
// move has passed the input register, then the result register; there is no
// way to hold results off, so the receiver must take every strobe. A move sees
// the effect of every move taken before it, also the one right before.
module geometry_coprocessor_register_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  output logic [31:0] out_read_data
);
  import gcra_pkg::*;

  logic        vld_r;
  action_t     act_r;
  logic [4:0]  idx_r;
  logic [31:0] val_r;

  logic [31:0] data_r [32];
  logic [31:0] ctrl_r [32];

  logic        out_valid_r;
  logic [31:0] rd_r;
  logic [31:0] rd_nxt;
  logic [31:0] data_rd;
  logic [31:0] ctrl_wr;
  logic [31:0] flag_masked;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r <= action_t'(in_action);
      idx_r <= in_reg_index;
      val_r <= in_write_value;
    end
  end

  // read side
  always_comb begin
    if (idx_r inside {D_VZ0, D_VZ1, D_VZ2, D_IR0, D_IR1, D_IR2, D_IR3}) begin
      data_rd = sext16(data_r[idx_r]);
    end else if (idx_r inside {D_OTZ, D_SZ0, D_SZ1, D_SZ2, D_SZ3}) begin
      data_rd = {16'd0, data_r[idx_r][15:0]};
    end else if (idx_r == D_SXYP) begin
      data_rd = data_r[D_SXY2];
    end else if (idx_r inside {D_IRGB, D_ORGB}) begin
      data_rd = {17'd0, colour_part(data_r[D_IR3]), colour_part(data_r[D_IR2]),
                 colour_part(data_r[D_IR1])};
    end else begin
      data_rd = data_r[idx_r];
    end

    case (act_r)
      ACT_DATA_RD: rd_nxt = data_rd;
      ACT_CTRL_RD: rd_nxt = ctrl_r[idx_r];
      default:     rd_nxt = 32'd0;
    endcase
  end

  // control write value
  always_comb begin
    flag_masked = val_r & FLAG_MASK;
    if (idx_r inside {C_RT33, C_LL33, C_LC33, C_PRJH, C_DQA, C_ZSF3, C_ZSF4}) begin
      ctrl_wr = sext16(val_r);
    end else if (idx_r == C_FLAG) begin
      ctrl_wr = {|(val_r & FLAG_ERR), flag_masked[30:0]};
    end else begin
      ctrl_wr = val_r;
    end
  end

  // register banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        data_r[i] <= 32'd0;
        ctrl_r[i] <= 32'd0;
      end
    end else if (vld_r) begin
      case (act_r)
        ACT_DATA_WR: begin
          if (idx_r == D_SXYP) begin
            // screen xy fifo push
            data_r[D_SXY0] <= data_r[D_SXY1];
            data_r[D_SXY1] <= data_r[D_SXY2];
            data_r[D_SXY2] <= val_r;
            data_r[idx_r]  <= val_r;
          end else if (idx_r == D_IRGB) begin
            data_r[D_IR1] <= {20'd0, val_r[4:0], 7'd0};
            data_r[D_IR2] <= {20'd0, val_r[9:5], 7'd0};
            data_r[D_IR3] <= {20'd0, val_r[14:10], 7'd0};
            data_r[idx_r] <= val_r;
          end else if (idx_r == D_LZCS) begin
            data_r[D_LZCR] <= {26'd0, sign_run(val_r)};
            data_r[idx_r]  <= val_r;
          end else if (idx_r != D_LZCR) begin
            data_r[idx_r] <= val_r;
          end
        end
        ACT_CTRL_WR: begin
          ctrl_r[idx_r] <= ctrl_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      rd_r <= rd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rd_r;

endmodule

// ----- rtl/core/gcra_checker.sv -----
`timescale 1ns / 1ps
// gcra_checker: port-level checks on the register file's move timing and
// results, bound to the top level. Depends on gcra_pkg.
module gcra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic [4:0]  in_reg_index,
  input logic [31:0] in_write_value,
  input logic        out_valid,
  input logic [31:0] out_read_data
);
  import gcra_pkg::*;

  // every transfer in gives a result after the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("taken move gave no result");

  // no result without a transfer in ahead of it through the same registers
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 2))
    else $error("result without a move");

  // writes return zero
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_action, 2) == ACT_DATA_WR ||
                  $past(in_action, 2) == ACT_CTRL_WR) |-> out_read_data == 32'd0)
    else $error("write move returned nonzero data");

  // sxy push followed by a read of the push register returns the pushed value
  a_sxy_push_read: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == ACT_DATA_WR && in_reg_index == D_SXYP ##1
    start && !busy && in_action == ACT_DATA_RD && in_reg_index == D_SXYP
    |-> ##2 out_read_data == $past(in_write_value, 3))
    else $error("screen xy push not visible to next read");

  // packed colour fits in 15 bits
  a_colour_width: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == ACT_DATA_RD &&
    (in_reg_index == D_IRGB || in_reg_index == D_ORGB)
    |-> ##2 out_read_data[31:15] == 17'd0)
    else $error("packed colour has high bits set");

endmodule

bind geometry_coprocessor_register_access gcra_checker u_gcra_checker (.*);
